@@ rtl/core/mpf_pkg.sv @@
// Shared constants, types and sequencer states for the Markov prefetch table.
`timescale 1ns / 1ps
package mpf_pkg;

	localparam int ADDR_W            = 64;
	localparam int BLOCK_OFFSET_BITS = 6;
	localparam int LINE_W            = ADDR_W - BLOCK_OFFSET_BITS;
	localparam int NUM_ENTRIES       = 8;
	localparam int NUM_SUCCESSORS    = 4;
	localparam int ENT_W             = $clog2(NUM_ENTRIES);
	localparam int SLOT_W            = $clog2(NUM_SUCCESSORS);
	localparam int SADDR_W           = ENT_W + SLOT_W;
	localparam int NUM_SLOTS         = NUM_ENTRIES * NUM_SUCCESSORS;
	localparam int COUNT_W           = 16;
	localparam int TOTAL_W           = 18;

	typedef logic [LINE_W-1:0]  line_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [TOTAL_W-1:0] total_t;
	typedef logic [ENT_W-1:0]   ent_t;
	typedef logic [SLOT_W-1:0]  slot_idx_t;
	typedef logic [SADDR_W-1:0] saddr_t;

	localparam count_t    COUNT_MAX = '1;
	localparam total_t    TOTAL_MAX = '1;
	localparam slot_idx_t SLOT_LAST = slot_idx_t'(NUM_SUCCESSORS - 1);

	localparam logic CMD_RECORD = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_EVICT_RD,
		ST_EVICT_WR,
		ST_RETAG,
		ST_READ_RD,
		ST_READ_OUT
	} state_t;

	// One successor slot as read back from the slot store; empty slots read as zero.
	typedef struct packed {
		line_t  line;
		count_t count;
	} slot_t;

	// Control from the sequencer to the slot store.
	typedef struct packed {
		logic   rd_en;
		saddr_t rd_addr;
		logic   wr_en;
		saddr_t wr_addr;
		line_t  wr_line;
		count_t wr_count;
		logic   clr_en;
		ent_t   clr_ent;
	} slot_ctl_t;

endpackage

@@ rtl/core/mpf_if.sv @@
// Request and response channel interfaces of the Markov prefetch table.
`timescale 1ns / 1ps
interface mpf_req_if
	import mpf_pkg::*;
	;
	logic                  valid;
	logic                  ready;
	logic                  command;
	logic [ADDR_W-1:0]     address;
	logic [ENT_W-1:0]      entry_index;
	logic [SLOT_W-1:0]     slot_index;

	modport source (output valid, command, address, entry_index, slot_index, input ready);
	modport sink   (input valid, command, address, entry_index, slot_index, output ready);
endinterface

interface mpf_rsp_if
	import mpf_pkg::*;
	;
	logic               valid;
	logic               ready;
	logic               tag_hit;
	logic               new_transition;
	logic [LINE_W-1:0]  entry_line;
	logic [TOTAL_W-1:0] match_total;
	logic [LINE_W-1:0]  successor_line;
	logic [COUNT_W-1:0] successor_count;

	modport source (output valid, tag_hit, new_transition, entry_line, match_total,
		successor_line, successor_count, input ready);
	modport sink   (input valid, tag_hit, new_transition, entry_line, match_total,
		successor_line, successor_count, output ready);
endinterface

@@ rtl/core/mpf_slot_store.sv @@
// Successor slot memory with per-slot valid bits and a registered read port.
`timescale 1ns / 1ps
module mpf_slot_store
	import mpf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  slot_ctl_t ctl,
	output slot_t     rd
);

	line_t  line_mem [NUM_SLOTS];
	count_t cnt_mem  [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] vld_q;
	line_t  rd_line_q;
	count_t rd_cnt_q;
	logic   rd_vld_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			line_mem[ctl.wr_addr] <= ctl.wr_line;
			cnt_mem[ctl.wr_addr]  <= ctl.wr_count;
		end
		if (ctl.rd_en) begin
			rd_line_q <= line_mem[ctl.rd_addr];
			rd_cnt_q  <= cnt_mem[ctl.rd_addr];
		end
	end

	// Valid bits: clear on reset and on retag of an entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				vld_q[ctl.wr_addr] <= 1'b1;
			end
			if (ctl.clr_en) begin
				for (int s = 0; s < NUM_SUCCESSORS; s++) begin
					vld_q[{ctl.clr_ent, slot_idx_t'(s)}] <= 1'b0;
				end
			end
			if (ctl.rd_en) begin
				rd_vld_q <= vld_q[ctl.rd_addr];
			end
		end
	end

	// An invalid slot reads as empty.
	assign rd.line  = rd_vld_q ? rd_line_q : '0;
	assign rd.count = rd_vld_q ? rd_cnt_q : '0;

endmodule

@@ rtl/core/mpf_update_unit.sv @@
// Shared slot compare and saturating count arithmetic.
`timescale 1ns / 1ps
module mpf_update_unit
	import mpf_pkg::*;
(
	input  slot_t  rd,
	input  line_t  line,
	input  total_t total,
	output logic   match,
	output count_t count_inc,
	output total_t total_inc,
	output total_t total_evict
);

	total_t evicted;

	assign match       = (rd.count != '0) && (rd.line == line);
	assign count_inc   = (rd.count == COUNT_MAX) ? rd.count : rd.count + count_t'(1);
	assign total_inc   = (total == TOTAL_MAX) ? total : total + total_t'(1);
	assign evicted     = total_t'(rd.count);
	// Subtract the evicted count from the credited total, floor at zero.
	assign total_evict = (total_inc >= evicted) ? total_inc - evicted : '0;

endmodule

@@ rtl/core/markov_prefetch_table_update_core.sv @@
// Top level of the Markov prefetch table: sequencer, entry table and output register.
`timescale 1ns / 1ps
// The table is direct mapped over the line number (byte address shifted right
// by the block offset); each entry keeps a tag, four successor slots with
// saturating counts, a FIFO replacement pointer and a saturating total. A
// record transaction credits the move from the previously touched entry to the
// new line, then retags the line's own entry (clearing its slots, total and
// pointer on a miss) and makes it the previous entry. A read transaction
// returns one slot of one entry and leaves the table untouched. One item is
// handled at a time: req.ready is high only while the sequencer is idle. The
// successor scan walks the slots one at a time through a single compare unit,
// and each slot is read in ST_SCAN_RD and compared in ST_SCAN_CMP because the
// slot memory read is registered. When all four slots miss, the slot at the
// FIFO pointer is read and overwritten (ST_EVICT_RD, ST_EVICT_WR). A finished
// result waits in the output register while the next transaction is
// accepted; the sequencer only stalls if a second result is ready before the
// first has been taken.
module markov_prefetch_table_update_core
	import mpf_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	mpf_req_if.sink        req,
	mpf_rsp_if.source      rsp
);

	state_t    state_q, state_d;

	// Latched transaction fields.
	logic      cmd_q;
	line_t     line_q;
	ent_t      rent_q;
	slot_idx_t rslot_q;
	slot_idx_t slot_q;
	logic      alloc_q;

	// Entry table.
	line_t     tags_q   [NUM_ENTRIES];
	total_t    totals_q [NUM_ENTRIES];
	slot_idx_t fifo_q   [NUM_ENTRIES];
	ent_t      prev_q;
	logic      prev_valid_q;

	// Output register.
	logic      out_valid_q;
	logic      out_hit_q;
	logic      out_alloc_q;
	line_t     out_eline_q;
	total_t    out_total_q;
	line_t     out_sline_q;
	count_t    out_scount_q;

	ent_t      e_line;
	ent_t      tidx;
	line_t     tag_rd;
	total_t    total_rd;
	slot_idx_t fifo_rd;
	logic      tag_hit;
	logic      out_free;
	logic      accept;

	slot_ctl_t slot_ctl;
	slot_t     slot_rd;
	logic      match;
	count_t    count_inc;
	total_t    total_inc;
	total_t    total_evict;

	mpf_slot_store u_slot_store (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (slot_ctl),
		.rd     (slot_rd)
	);

	mpf_update_unit u_update_unit (
		.rd          (slot_rd),
		.line        (line_q),
		.total       (total_rd),
		.match       (match),
		.count_inc   (count_inc),
		.total_inc   (total_inc),
		.total_evict (total_evict)
	);

	assign e_line   = line_q[ENT_W-1:0];
	assign out_free = !out_valid_q || rsp.ready;
	assign accept   = req.valid && req.ready;

	// One table read index: the read target, the previous entry while
	// crediting, or the line's own entry while retagging.
	always_comb begin
		if (cmd_q == CMD_READ) begin
			tidx = rent_q;
		end else if (state_q == ST_SCAN_RD || state_q == ST_SCAN_CMP ||
			state_q == ST_EVICT_RD || state_q == ST_EVICT_WR) begin
			tidx = prev_q;
		end else begin
			tidx = e_line;
		end
	end

	assign tag_rd   = tags_q[tidx];
	assign total_rd = totals_q[tidx];
	assign fifo_rd  = fifo_q[tidx];
	assign tag_hit  = (tag_rd == line_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					if (req.command == CMD_READ) begin
						state_d = ST_READ_RD;
					end else if (prev_valid_q) begin
						state_d = ST_SCAN_RD;
					end else begin
						state_d = ST_RETAG;
					end
				end
			end
			ST_SCAN_RD:  state_d = ST_SCAN_CMP;
			ST_SCAN_CMP: begin
				if (match) begin
					state_d = ST_RETAG;
				end else if (slot_q == SLOT_LAST) begin
					state_d = ST_EVICT_RD;
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_EVICT_RD: state_d = ST_EVICT_WR;
			ST_EVICT_WR: state_d = ST_RETAG;
			ST_RETAG: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ_RD:  state_d = ST_READ_OUT;
			ST_READ_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake and slot store control.
	always_comb begin
		req.ready         = 1'b0;
		slot_ctl          = '0;
		slot_ctl.wr_line  = line_q;
		slot_ctl.clr_ent  = e_line;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
			end
			ST_SCAN_RD: begin
				slot_ctl.rd_en   = 1'b1;
				slot_ctl.rd_addr = {prev_q, slot_q};
			end
			ST_SCAN_CMP: begin
				slot_ctl.wr_en    = match;
				slot_ctl.wr_addr  = {prev_q, slot_q};
				slot_ctl.wr_count = count_inc;
			end
			ST_EVICT_RD: begin
				slot_ctl.rd_en   = 1'b1;
				slot_ctl.rd_addr = {prev_q, fifo_rd};
			end
			ST_EVICT_WR: begin
				slot_ctl.wr_en    = 1'b1;
				slot_ctl.wr_addr  = {prev_q, fifo_rd};
				slot_ctl.wr_count = count_t'(1);
			end
			ST_RETAG: begin
				// Drop the entry's successors on a tag miss.
				slot_ctl.clr_en = out_free && !tag_hit;
			end
			ST_READ_RD: begin
				slot_ctl.rd_en   = 1'b1;
				slot_ctl.rd_addr = {rent_q, rslot_q};
			end
			default: begin
			end
		endcase
	end

	// Control state and the entry table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			prev_q       <= '0;
			prev_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				tags_q[i]   <= '0;
				totals_q[i] <= '0;
				fifo_q[i]   <= '0;
			end
		end else begin
			state_q <= state_d;
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_SCAN_CMP: begin
					if (match) begin
						totals_q[prev_q] <= total_inc;
					end
				end
				ST_EVICT_WR: begin
					totals_q[prev_q] <= total_evict;
					fifo_q[prev_q]   <= (fifo_rd == SLOT_LAST) ? '0 : fifo_rd + slot_idx_t'(1);
				end
				ST_RETAG: begin
					if (out_free) begin
						if (!tag_hit) begin
							tags_q[e_line]   <= line_q;
							totals_q[e_line] <= '0;
							fifo_q[e_line]   <= '0;
						end
						prev_q       <= e_line;
						prev_valid_q <= 1'b1;
						out_valid_q  <= 1'b1;
					end
				end
				ST_READ_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Transaction fields, scan pointer and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= req.command;
			line_q  <= req.address[ADDR_W-1:BLOCK_OFFSET_BITS];
			rent_q  <= req.entry_index;
			rslot_q <= req.slot_index;
			slot_q  <= '0;
			alloc_q <= 1'b0;
		end
		if (state_q == ST_SCAN_CMP && !match) begin
			slot_q <= slot_q + slot_idx_t'(1);
		end
		if (state_q == ST_EVICT_WR) begin
			alloc_q <= 1'b1;
		end
		if (state_q == ST_RETAG && out_free) begin
			out_hit_q    <= tag_hit;
			out_alloc_q  <= alloc_q;
			out_eline_q  <= '0;
			out_total_q  <= '0;
			out_sline_q  <= '0;
			out_scount_q <= '0;
		end
		if (state_q == ST_READ_OUT && out_free) begin
			out_hit_q    <= 1'b0;
			out_alloc_q  <= 1'b0;
			out_eline_q  <= tag_rd;
			out_total_q  <= total_rd;
			out_sline_q  <= slot_rd.line;
			out_scount_q <= slot_rd.count;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.tag_hit         = out_hit_q;
	assign rsp.new_transition  = out_alloc_q;
	assign rsp.entry_line      = out_eline_q;
	assign rsp.match_total     = out_total_q;
	assign rsp.successor_line  = out_sline_q;
	assign rsp.successor_count = out_scount_q;

	// Hold off new transactions while one is in flight.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("request accepted while a transaction was in flight");

	// Once a record has completed there is always a previous entry.
	a_prev_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(prev_valid_q))
		else $error("previous entry lost its valid mark");

	// A scan that misses on every slot must evict.
	a_scan_to_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN_CMP && !match && slot_q == SLOT_LAST) |=>
		(state_q == ST_EVICT_RD))
		else $error("full scan miss did not evict");

	// A read result never flags record outcomes.
	a_read_flags_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ_OUT && out_free) |=>
		(out_valid_q && !rsp.tag_hit && !rsp.new_transition))
		else $error("read result carries record flags");

endmodule

@@ test/tb_markov_prefetch_table_update_core.sv @@
// Self-checking testbench for the Markov prefetch table update core.
`timescale 1ns / 1ps
module tb_markov_prefetch_table_update_core;
	import mpf_pkg::*;

	localparam int RANDOM_ITEMS   = 1300;
	localparam int REPEAT_RECORDS = 40;
	localparam int CYCLE_LIMIT    = 3000000;
	localparam int DRAIN_CYCLES   = 16;

	typedef struct packed {
		logic   tag_hit;
		logic   new_transition;
		line_t  entry_line;
		total_t match_total;
		line_t  successor_line;
		count_t successor_count;
	} table_reply_t;

	logic clk;
	logic arst_n;

	mpf_req_if req_ch ();
	mpf_rsp_if rsp_ch ();

	markov_prefetch_table_update_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the table, updated as each request is accepted.
	line_t     shadow_tag   [NUM_ENTRIES];
	line_t     shadow_sline [NUM_SLOTS];
	count_t    shadow_count [NUM_SLOTS];
	slot_idx_t shadow_fifo  [NUM_ENTRIES];
	total_t    shadow_total [NUM_ENTRIES];
	ent_t      shadow_prev;
	logic      shadow_prev_vld;

	table_reply_t expected_replies [$];
	int mismatches  = 0;
	int cycle_count = 0;
	bit idle_on     = 1'b0;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Credit the move into line from entry e; return 1 when a slot was allocated.
	function automatic logic credit_successor(ent_t e, line_t line);
		int base;
		int victim;
		base = int'(e) * NUM_SUCCESSORS;
		if (shadow_total[e] != TOTAL_MAX)
			shadow_total[e]++;
		// Empty slots (count zero) never match, even for line zero.
		for (int s = 0; s < NUM_SUCCESSORS; s++) begin
			if (shadow_count[base + s] != '0 && shadow_sline[base + s] == line) begin
				if (shadow_count[base + s] != COUNT_MAX)
					shadow_count[base + s]++;
				return 1'b0;
			end
		end
		victim = base + int'(shadow_fifo[e]);
		if (shadow_total[e] >= total_t'(shadow_count[victim]))
			shadow_total[e] = shadow_total[e] - total_t'(shadow_count[victim]);
		else
			shadow_total[e] = '0;
		shadow_sline[victim] = line;
		shadow_count[victim] = count_t'(1);
		shadow_fifo[e] = slot_idx_t'((int'(shadow_fifo[e]) + 1) % NUM_SUCCESSORS);
		return 1'b1;
	endfunction

	// Apply one request to the shadow table and return the reply it must produce.
	function automatic table_reply_t table_update_reply(logic cmd, logic [ADDR_W-1:0] addr,
		ent_t ent, slot_idx_t slot);
		table_reply_t r;
		line_t line;
		ent_t home;
		r = '0;
		if (cmd == CMD_RECORD) begin
			line = addr[ADDR_W-1:BLOCK_OFFSET_BITS];
			home = ent_t'(line % NUM_ENTRIES);
			// Credit first: a retag of the same entry then wipes the slot just written.
			if (shadow_prev_vld)
				r.new_transition = credit_successor(shadow_prev, line);
			r.tag_hit = (shadow_tag[home] == line);
			if (!r.tag_hit) begin
				shadow_tag[home] = line;
				for (int s = 0; s < NUM_SUCCESSORS; s++) begin
					shadow_sline[int'(home) * NUM_SUCCESSORS + s] = '0;
					shadow_count[int'(home) * NUM_SUCCESSORS + s] = '0;
				end
				shadow_total[home] = '0;
				shadow_fifo[home]  = '0;
			end
			shadow_prev     = home;
			shadow_prev_vld = 1'b1;
		end else begin
			r.entry_line      = shadow_tag[ent];
			r.match_total     = shadow_total[ent];
			r.successor_line  = shadow_sline[int'(ent) * NUM_SUCCESSORS + int'(slot)];
			r.successor_count = shadow_count[int'(ent) * NUM_SUCCESSORS + int'(slot)];
		end
		return r;
	endfunction

	function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	// Check every reply transaction against the oldest pending expectation.
	always @(posedge clk) begin
		table_reply_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_replies.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected reply: expected none, actual entry_line %0h",
					$time, rsp_ch.entry_line);
			end else begin
				want = expected_replies.pop_front();
				compare_field("tag_hit", 64'(want.tag_hit), 64'(rsp_ch.tag_hit));
				compare_field("new_transition", 64'(want.new_transition),
					64'(rsp_ch.new_transition));
				compare_field("entry_line", 64'(want.entry_line), 64'(rsp_ch.entry_line));
				compare_field("match_total", 64'(want.match_total), 64'(rsp_ch.match_total));
				compare_field("successor_line", 64'(want.successor_line),
					64'(rsp_ch.successor_line));
				compare_field("successor_count", 64'(want.successor_count),
					64'(rsp_ch.successor_count));
			end
		end
	end

	// Reply sink: stall in random bursts while idling is on, otherwise take every reply.
	initial begin
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 15) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
		end
	end

	// Drive one request transaction and record its expected reply once accepted.
	task automatic send_item(logic cmd, logic [ADDR_W-1:0] addr, ent_t ent, slot_idx_t slot);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.command     <= cmd;
		req_ch.address     <= addr;
		req_ch.entry_index <= ent;
		req_ch.slot_index  <= slot;
		do @(posedge clk); while (!req_ch.ready);
		expected_replies.push_back(table_update_reply(cmd, addr, ent, slot));
	endtask

	task automatic record_line(line_t line);
		logic [ADDR_W-1:0] addr;
		addr = {$urandom, $urandom};
		addr[ADDR_W-1:BLOCK_OFFSET_BITS] = line;
		send_item(CMD_RECORD, addr, ent_t'($urandom), slot_idx_t'($urandom));
	endtask

	task automatic read_slot(ent_t ent, slot_idx_t slot);
		send_item(CMD_READ, {$urandom, $urandom}, ent, slot);
	endtask

	// Hold the request side until every outstanding reply has arrived.
	task automatic drain_replies();
		req_ch.valid <= 1'b0;
		while (expected_replies.size() != 0) @(posedge clk);
	endtask

	task automatic test_reset_contents();
		read_slot('0, '0);
		read_slot('1, SLOT_LAST);
	endtask

	// Line zero hits its reset tag; the empty slot must not match line zero.
	task automatic test_line_zero_and_self_transition();
		send_item(CMD_RECORD, '0, '1, '1);
		send_item(CMD_RECORD, 64'h3f, '0, '0);
		send_item(CMD_RECORD, '0, '0, '0);
		read_slot('0, '0);
	endtask

	// Widest address, then records that credit and retag the same entry.
	task automatic test_extreme_address_and_retag();
		send_item(CMD_RECORD, '1, '0, '0);
		read_slot('1, '0);
		record_line(line_t'(15));
		record_line(line_t'(23));
		read_slot('1, '0);
	endtask

	// Give entry 1 five distinct successors so the oldest slot is evicted.
	task automatic test_fifo_eviction();
		for (int k = 2; k <= 6; k++) begin
			record_line(line_t'(1));
			record_line(line_t'(k));
		end
		read_slot(ent_t'(1), '0);
		read_slot(ent_t'(1), slot_idx_t'(1));
	endtask

	// Replay short line patterns from a small pool so successors repeat and
	// tags collide, with some stray lines and reads mixed in.
	task automatic test_random_traffic();
		line_t pool [16];
		int pattern [4];
		int plen;
		int step;
		int pick;
		for (int i = 0; i < 16; i++) begin
			pool[i] = line_t'({$urandom, $urandom});
			pool[i][ENT_W-1:0] = ent_t'(i % NUM_ENTRIES);
		end
		pool[0]  = '0;
		pool[15] = '1;
		plen = 2;
		step = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Leave stretches with no idling on either side.
			idle_on = (n % 300) < 230;
			if (n % 40 == 0) begin
				plen = $urandom_range(2, 4);
				step = 0;
				foreach (pattern[k])
					pattern[k] = $urandom_range(0, 15);
			end
			if (n % 97 == 96)
				pool[$urandom_range(1, 14)] = line_t'({$urandom, $urandom});
			if (n == RANDOM_ITEMS / 2)
				drain_replies();
			pick = $urandom_range(0, 99);
			if (pick < 20) begin
				read_slot(ent_t'($urandom), slot_idx_t'($urandom));
			end else if (pick < 75) begin
				record_line(pool[pattern[step]]);
				step = (step + 1) % plen;
			end else if (pick < 95) begin
				record_line(pool[$urandom_range(0, 15)]);
			end else begin
				send_item(CMD_RECORD, {$urandom, $urandom}, ent_t'($urandom),
					slot_idx_t'($urandom));
			end
		end
	endtask

	// Repeat one line back to back so its self slot and entry total climb.
	task automatic test_repeated_line();
		line_t line;
		line = line_t'({$urandom, $urandom});
		for (int n = 0; n < REPEAT_RECORDS; n++)
			record_line(line);
		for (int s = 0; s < NUM_SUCCESSORS; s++)
			read_slot(ent_t'(line % NUM_ENTRIES), slot_idx_t'(s));
		// Push new successors through so the heavily counted slot gets evicted.
		for (int k = 1; k <= NUM_SUCCESSORS; k++) begin
			record_line(line + line_t'(k));
			record_line(line);
		end
		read_slot(ent_t'(line % NUM_ENTRIES), '0);
	endtask

	initial begin
		arst_n             <= 1'b0;
		req_ch.valid       <= 1'b0;
		req_ch.command     <= CMD_RECORD;
		req_ch.address     <= '0;
		req_ch.entry_index <= '0;
		req_ch.slot_index  <= '0;
		for (int e = 0; e < NUM_ENTRIES; e++) begin
			shadow_tag[e]   = '0;
			shadow_fifo[e]  = '0;
			shadow_total[e] = '0;
		end
		for (int s = 0; s < NUM_SLOTS; s++) begin
			shadow_sline[s] = '0;
			shadow_count[s] = '0;
		end
		shadow_prev     = '0;
		shadow_prev_vld = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_on = 1'b1;
		test_reset_contents();
		test_line_zero_and_self_transition();
		test_extreme_address_and_retag();
		test_fifo_eviction();
		drain_replies();
		test_random_traffic();
		drain_replies();
		idle_on = 1'b0;
		test_repeated_line();

		drain_replies();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
